### src/cia_pp_pkg.sv
// Shared types and constants for the CiA402 profile-position axis sequencer.
// No dependencies; every other file in src imports this package.
package cia_pp_pkg;

    localparam int SW_W  = 16;
    localparam int POS_W = 32;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] FAULT_LOW_RST = 8'd10;
    localparam logic [CNT_W-1:0] PRELOAD_RST   = 8'd20;

    // Status word bits and decode patterns
    localparam int SW_FAULT_BIT = 3;
    localparam int SW_ACK_BIT   = 12;
    localparam logic [SW_W-1:0] SW_MASK_SOD  = 16'h004F;
    localparam logic [SW_W-1:0] SW_PAT_SOD   = 16'h0040;
    localparam logic [SW_W-1:0] SW_MASK_ENA  = 16'h006F;
    localparam logic [SW_W-1:0] SW_PAT_RTSO  = 16'h0021;
    localparam logic [SW_W-1:0] SW_PAT_SO    = 16'h0023;
    localparam logic [SW_W-1:0] SW_PAT_OE    = 16'h0027;

    // Control words
    localparam logic [SW_W-1:0] CW_ZERO      = 16'h0000;
    localparam logic [SW_W-1:0] CW_FAULT_RST = 16'h0080;
    localparam logic [SW_W-1:0] CW_SHUTDOWN  = 16'h0006;
    localparam logic [SW_W-1:0] CW_SWITCH_ON = 16'h0007;
    localparam logic [SW_W-1:0] CW_ENABLE    = 16'h000F;
    localparam logic [SW_W-1:0] CW_NEW_SP    = 16'h003F;

    typedef enum logic [0:0] {
        CFG_FAULT_LOW = 1'b0,
        CFG_PRELOAD   = 1'b1
    } t_cfg_idx;

    typedef enum logic [5:0] {
        DS_FAULT = 6'b000001,
        DS_SOD   = 6'b000010,
        DS_RTSO  = 6'b000100,
        DS_SO    = 6'b001000,
        DS_OE    = 6'b010000,
        DS_OTHER = 6'b100000
    } t_drive_state;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_SET     = 3'b010,
        PH_RELEASE = 3'b100
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] fault_low_cycles;
        logic [CNT_W-1:0] preload_cycles;
    } t_cfg;

    typedef struct packed {
        logic [SW_W-1:0]         drive_status;
        logic signed [POS_W-1:0] actual_pos;
        logic                    target_valid;
        logic signed [POS_W-1:0] desired_pos;
    } t_item;

    typedef struct packed {
        logic [SW_W-1:0]         control_word;
        logic signed [POS_W-1:0] target_pos;
    } t_result;

endpackage

### src/cia_pp_if.sv
// Valid/ready channel interfaces: input item, result item and configuration write.
// Depends on cia_pp_pkg.
interface cia_pp_in_if import cia_pp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SW_W-1:0]         drive_status;
    logic signed [POS_W-1:0] actual_pos;
    logic                    target_valid;
    logic signed [POS_W-1:0] desired_pos;

    modport source (output valid, drive_status, actual_pos, target_valid, desired_pos,
                    input ready);
    modport sink   (input valid, drive_status, actual_pos, target_valid, desired_pos,
                    output ready);
endinterface

interface cia_pp_out_if import cia_pp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SW_W-1:0]         control_word;
    logic signed [POS_W-1:0] target_pos;

    modport source (output valid, control_word, target_pos, input ready);
    modport sink   (input valid, control_word, target_pos, output ready);
endinterface

interface cia_pp_cfg_if import cia_pp_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [CNT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/cia_pp_core.sv
// Drive state decode, fault-reset timing and set-point handshake with its state.
// Depends on cia_pp_pkg. State advances only when i_adv is high.
module cia_pp_core import cia_pp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    logic [CNT_W-1:0]  r_fault_count, n_fault_count;
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_preload_count, n_preload_count;
    logic [POS_W-1:0]  r_latched_pos, n_latched_pos;
    logic              r_latched_once, n_latched_once;
    logic              r_enable_seen, n_enable_seen;

    t_drive_state      ds;
    logic [POS_W-1:0]  ref_pos;
    logic              ack;

    always_comb begin
        if (i_item.drive_status[SW_FAULT_BIT]) begin
            ds = DS_FAULT;
        end else if ((i_item.drive_status & SW_MASK_SOD) == SW_PAT_SOD) begin
            ds = DS_SOD;
        end else if ((i_item.drive_status & SW_MASK_ENA) == SW_PAT_RTSO) begin
            ds = DS_RTSO;
        end else if ((i_item.drive_status & SW_MASK_ENA) == SW_PAT_SO) begin
            ds = DS_SO;
        end else if ((i_item.drive_status & SW_MASK_ENA) == SW_PAT_OE) begin
            ds = DS_OE;
        end else begin
            ds = DS_OTHER;
        end
    end

    assign ack     = i_item.drive_status[SW_ACK_BIT];
    // First entry to operation enabled latches the actual position before the compare
    assign ref_pos = r_enable_seen ? r_latched_pos : i_item.actual_pos;

    always_comb begin
        n_fault_count   = r_fault_count;
        n_phase         = r_phase;
        n_preload_count = r_preload_count;
        n_latched_pos   = r_latched_pos;
        n_latched_once  = r_latched_once;
        n_enable_seen   = r_enable_seen;
        o_res.control_word = CW_SHUTDOWN;
        o_res.target_pos   = i_item.actual_pos;

        case (ds)
            DS_FAULT: begin
                if (r_fault_count < i_cfg.fault_low_cycles) begin
                    o_res.control_word = CW_ZERO;
                    n_fault_count      = r_fault_count + 1'b1;
                end else begin
                    o_res.control_word = CW_FAULT_RST;
                    n_fault_count      = '0;
                end
            end
            DS_SOD:  o_res.control_word = CW_SHUTDOWN;
            DS_RTSO: o_res.control_word = CW_SWITCH_ON;
            DS_SO:   o_res.control_word = CW_ENABLE;
            DS_OE: begin
                if (!r_enable_seen) begin
                    n_enable_seen = 1'b1;
                    n_latched_pos = i_item.actual_pos;
                end
                o_res.control_word = CW_ENABLE;
                if (i_item.target_valid) begin
                    o_res.target_pos = i_item.desired_pos;
                    case (r_phase)
                        PH_IDLE: begin
                            if (i_item.desired_pos != ref_pos || !r_latched_once) begin
                                if (r_preload_count < i_cfg.preload_cycles) begin
                                    n_preload_count = r_preload_count + 1'b1;
                                end else begin
                                    n_phase = PH_SET;
                                end
                            end else begin
                                n_preload_count = '0;
                            end
                        end
                        PH_SET: begin
                            o_res.control_word = CW_NEW_SP;
                            if (ack) begin
                                n_phase = PH_RELEASE;
                            end
                        end
                        default: begin
                            // release: latch once the acknowledge clears
                            if (!ack) begin
                                n_latched_pos   = i_item.desired_pos;
                                n_latched_once  = 1'b1;
                                n_phase         = PH_IDLE;
                                n_preload_count = '0;
                            end
                        end
                    endcase
                end
            end
            default: o_res.control_word = CW_SHUTDOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_count   <= '0;
            r_phase         <= PH_IDLE;
            r_preload_count <= '0;
            r_latched_pos   <= '0;
            r_latched_once  <= 1'b0;
            r_enable_seen   <= 1'b0;
        end else if (i_adv) begin
            r_fault_count   <= n_fault_count;
            r_phase         <= n_phase;
            r_preload_count <= n_preload_count;
            r_latched_pos   <= n_latched_pos;
            r_latched_once  <= n_latched_once;
            r_enable_seen   <= n_enable_seen;
        end
    end

endmodule

### src/cia402_pp_axis_sequencer.sv
// CiA402 profile-position axis sequencer: one control word and target per bus cycle.
// Pipeline: the accepted input item is registered, then its core result is held in the result register.
// Throughput: one transaction per cycle while the result is not stalled; a stalled result stalls the input.
// Reset (synchronous, active low): clears pipeline valids and sequencer state,
// restores fault_low_cycles to 10 and preload_cycles to 20.
// Depends on cia_pp_pkg, cia_pp_if and cia_pp_core.
module cia402_pp_axis_sequencer import cia_pp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cia_pp_in_if.sink     i_in,
    cia_pp_cfg_if.sink    i_cfg,
    cia_pp_out_if.source  o_out
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result core_res;
    logic    adv;

    assign adv          = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready   = !r_in_valid || adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fault_low_cycles <= FAULT_LOW_RST;
            r_cfg.preload_cycles   <= PRELOAD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FAULT_LOW: r_cfg.fault_low_cycles <= i_cfg.data;
                CFG_PRELOAD:   r_cfg.preload_cycles   <= i_cfg.data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.drive_status <= i_in.drive_status;
            r_item.actual_pos   <= i_in.actual_pos;
            r_item.target_valid <= i_in.target_valid;
            r_item.desired_pos  <= i_in.desired_pos;
        end
    end

    cia_pp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= core_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.control_word = r_res.control_word;
    assign o_out.target_pos   = r_res.target_pos;

endmodule

### src/cia_pp_checker.sv
// Port-level checks for cia402_pp_axis_sequencer, attached by bind.
// Depends on cia_pp_pkg.
module cia_pp_checker import cia_pp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [SW_W-1:0]   i_control_word,
    input logic [POS_W-1:0]  i_target_pos
);

    // Input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled while result side free");

    // Every result carries one of the sequencer's control words
    a_cw_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_control_word == CW_ZERO || i_control_word == CW_FAULT_RST ||
                         i_control_word == CW_SHUTDOWN || i_control_word == CW_SWITCH_ON ||
                         i_control_word == CW_ENABLE || i_control_word == CW_NEW_SP))
        else $error("illegal control word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_control_word) && $stable(i_target_pos)))
        else $error("result changed while stalled");

    // An accepted input shows up as a result valid once it has passed the input and result registers
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("input transaction produced no result");

endmodule

bind cia402_pp_axis_sequencer cia_pp_checker u_cia_pp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_control_word (o_out.control_word),
    .i_target_pos   (o_out.target_pos)
);
